/* hw/rtl/ffra_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and codes of the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  typedef struct packed {
    logic        func;
    logic [31:0] request_size;
    logic [31:0] free_address;
  } in_t;

  typedef struct packed {
    logic [31:0] granted_address;
    logic        status;
  } out_t;

  // One region of the table
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } state_t;

  localparam logic FUNC_ALLOC  = 1'b0;
  localparam logic FUNC_FREE   = 1'b1;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 2'd1;

endpackage

/* hw/rtl/ffra_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_cell
// One slot of the region ring: holds a region and takes its neighbor's
// region on every shift.
// ----------------------------------------------------------------------------
module ffra_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  ffra_pkg::entry_t d,
  output ffra_pkg::entry_t q
);
  import ffra_pkg::*;

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

/* hw/rtl/ffra_head.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_head
// Ring head: request sequencer, gap compare, insert and remove, result
// register.
// ----------------------------------------------------------------------------
module ffra_head #(
  parameter  int MAX_REGIONS = 16,
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ffra_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ffra_pkg::out_t   out_data,
  input  logic [31:0]      region_base,
  input  logic [31:0]      region_size,
  input  ffra_pkg::entry_t slot0,
  input  ffra_pkg::entry_t slot1,
  output ffra_pkg::entry_t tail,
  output logic             shift_en,
  output logic [CNT_W-1:0] count
);
  import ffra_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_REGIONS);
  localparam logic [CNT_W-1:0] STEP_END = CNT_W'(MAX_REGIONS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             found_r, found_nxt;
  logic             stop_r, stop_nxt;
  logic             func_r, func_nxt;
  logic [31:0]      req_r, req_nxt;
  logic [31:0]      addr_r, addr_nxt;
  logic [32:0]      cursor_r, cursor_nxt;
  logic [32:0]      wend_r, wend_nxt;
  entry_t           hold_r;
  out_t             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    found_r    <= found_nxt;
    stop_r     <= stop_nxt;
    func_r     <= func_nxt;
    req_r      <= req_nxt;
    addr_r     <= addr_nxt;
    cursor_r   <= cursor_nxt;
    wend_r     <= wend_nxt;
    hold_r     <= slot0;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    logic        active;
    logic        in_table;
    logic [32:0] gap_end;
    logic [33:0] need_end;
    logic        fits;
    logic        hit;

    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    found_nxt     = found_r;
    stop_nxt      = stop_r;
    func_nxt      = func_r;
    req_nxt       = req_r;
    addr_nxt      = addr_r;
    cursor_nxt    = cursor_r;
    wend_nxt      = wend_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    shift_en      = 1'b0;
    tail          = slot0;

    active   = !found_r && !stop_r;
    in_table = step_r < count_r;
    gap_end  = in_table ? {1'b0, slot0.start} : wend_r;
    need_end = {2'b00, cursor_r[31:0]} + {2'b00, req_r};
    fits     = {1'b0, gap_end} >= need_end;
    hit      = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          func_nxt   = in_data.func;
          req_nxt    = in_data.request_size;
          addr_nxt   = in_data.free_address;
          step_nxt   = '0;
          found_nxt  = 1'b0;
          stop_nxt   = 1'b0;
          cursor_nxt = {1'b0, region_base};
          wend_nxt   = {1'b0, region_base} + {1'b0, region_size};
          res_nxt    = '{granted_address: 32'd0, status: STATUS_FAIL};
          if ((in_data.func == FUNC_ALLOC && count_r == CNT_MAX) ||
              (in_data.func == FUNC_FREE && count_r == '0)) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end

      ST_RUN: begin
        shift_en = 1'b1;
        if (func_r == FUNC_ALLOC) begin
          if (active && step_r <= count_r) begin
            if (cursor_r[32]) begin
              // gap starts past the address space: give up
              stop_nxt = 1'b1;
            end else if (fits) begin
              hit = 1'b1;
              res_nxt = '{granted_address: cursor_r[31:0], status: STATUS_DONE};
            end else if (in_table) begin
              cursor_nxt = {1'b0, slot0.start} + {1'b0, slot0.length};
            end
          end
          // insert: new region here, then each later region one slot down
          if (found_r) begin
            tail = hold_r;
          end else if (hit) begin
            tail = '{start: cursor_r[31:0], length: req_r};
          end
        end else begin
          hit = active && in_table && (slot0.start == addr_r);
          if (hit) begin
            res_nxt = '{granted_address: 32'd0, status: STATUS_DONE};
          end
          // remove: pull each later region one slot up
          if (found_r || hit) begin
            tail = slot1;
          end
        end
        if (hit) begin
          found_nxt = 1'b1;
        end

        if (step_r == STEP_END) begin
          state_nxt = ST_EMIT;
          if (found_r || hit) begin
            count_nxt = (func_r == FUNC_ALLOC) ? count_r + 1'b1 : count_r - 1'b1;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign count     = count_r;

endmodule

/* hw/rtl/first_fit_region_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_core
// First-fit allocator over one address window, table held in a ring of cells.
// ----------------------------------------------------------------------------
// The region table lives in a ring of MAX_REGIONS cells that rotates one slot
// per cycle while a request runs, past a single head, which checks gaps,
// inserts a new region or drops a freed one while the ring turns. A request
// is taken while idle, makes one full turn of the ring and waits in the
// result state for the output; an allocate against a full table or a free
// against an empty one skips the turn. One request is in work at a time; a
// new one is taken while the previous result still waits at the output.
// Write region_base and region_size only while no request is open.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_core #(
  parameter int MAX_REGIONS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ffra_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ffra_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ffra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);
  import ffra_pkg::*;

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  logic [31:0]      region_base_r;
  logic [31:0]      region_size_r;
  entry_t           cell_q [MAX_REGIONS];
  entry_t           slot1;
  entry_t           tail;
  logic             shift_en;
  logic [CNT_W-1:0] count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_base_r <= '0;
      region_size_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_REGION_BASE: region_base_r <= cfg_data;
        CFG_REGION_SIZE: region_size_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_ring
    if (i == MAX_REGIONS - 1) begin : g_last
      ffra_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d        (tail),
        .q        (cell_q[i])
      );
    end else begin : g_mid
      ffra_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .d        (cell_q[i+1]),
        .q        (cell_q[i])
      );
    end
  end

  if (MAX_REGIONS > 1) begin : g_slot1
    assign slot1 = cell_q[1];
  end else begin : g_slot1_single
    assign slot1 = cell_q[0];
  end

  ffra_head #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_head (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .region_base (region_base_r),
    .region_size (region_size_r),
    .slot0       (cell_q[0]),
    .slot1       (slot1),
    .tail        (tail),
    .shift_en    (shift_en),
    .count       (count)
  );

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == STATUS_FAIL) |-> (out_data.granted_address == 32'd0))
    else $error("failed result carries an address");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request transfer did not start work");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CNT_W'(MAX_REGIONS))
    else $error("region count beyond table depth");

  a_count_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(count) |-> $past(in_stall))
    else $error("region count changed with no request in work");

endmodule

/* test/first_fit_region_allocator_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_region_allocator_checker
// Predicts every allocator result and compares it with what the core returns.
// ----------------------------------------------------------------------------
// Watches the register, request and result channels. Register writes update a
// private copy of the window. Each request transfer runs a first-fit placement
// or a release against a private region table and queues the grant it must
// produce. Each result transfer is checked field by field against the oldest
// queued grant. Mismatch count and number of outstanding grants go to the top.
// ----------------------------------------------------------------------------
module first_fit_region_allocator_checker #(
  parameter int MAX_REGIONS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  ffra_pkg::in_t                  in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  ffra_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [ffra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import ffra_pkg::*;

  localparam longint ADDR_MAX = 64'h0000_0000_FFFF_FFFF;

  logic [31:0] win_base;
  logic [31:0] win_size;
  logic [31:0] region_start [MAX_REGIONS];
  logic [31:0] region_length [MAX_REGIONS];
  int          region_count;
  out_t        awaited_grants [$];

  task automatic flag_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // First fit over the gaps in address order, then insert in place
  task automatic place_region(input logic [31:0] want, output out_t res);
    longint cursor;
    longint wend;
    longint gap_end;
    longint need;
    int     slot;
    int     k;
    cursor = {32'd0, win_base};
    wend   = cursor + {32'd0, win_size};
    need   = {32'd0, want};
    slot   = -1;
    res.granted_address = '0;
    res.status          = STATUS_FAIL;
    if (region_count < MAX_REGIONS) begin
      for (k = 0; k <= region_count; k++) begin
        gap_end = (k < region_count) ? {32'd0, region_start[k]} : wend;
        // a gap starting past the address space ends the scan
        if (cursor > ADDR_MAX) break;
        if (gap_end - cursor >= need) begin
          slot = k;
          break;
        end
        if (k < region_count) begin
          cursor = {32'd0, region_start[k]} + {32'd0, region_length[k]};
        end
      end
    end
    if (slot >= 0) begin
      for (k = region_count; k > slot; k--) begin
        region_start[k]  = region_start[k-1];
        region_length[k] = region_length[k-1];
      end
      region_start[slot]  = cursor[31:0];
      region_length[slot] = want;
      region_count++;
      res.granted_address = cursor[31:0];
      res.status          = STATUS_DONE;
    end
  endtask

  // Drop the first region starting at addr
  task automatic release_region(input logic [31:0] addr, output out_t res);
    int slot;
    int k;
    slot = -1;
    for (k = 0; k < region_count; k++) begin
      if (region_start[k] == addr) begin
        slot = k;
        break;
      end
    end
    res.granted_address = '0;
    res.status          = (slot >= 0) ? STATUS_DONE : STATUS_FAIL;
    if (slot >= 0) begin
      for (k = slot; k + 1 < region_count; k++) begin
        region_start[k]  = region_start[k+1];
        region_length[k] = region_length[k+1];
      end
      region_count--;
    end
  endtask

  always @(posedge clk) begin
    out_t got_res;
    out_t want_res;
    out_t new_res;
    if (!rst_n) begin
      win_base     = '0;
      win_size     = '0;
      region_count = 0;
      awaited_grants.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_REGION_BASE: win_base = cfg_data;
          CFG_REGION_SIZE: win_size = cfg_data;
          default: ;
        endcase
      end
      // results first: one accepted now belongs to an earlier request
      if (out_valid && !out_stall) begin
        got_res = out_data;
        if (awaited_grants.size() == 0) begin
          flag_mismatch($sformatf("unexpected result addr=%h status=%0d",
                                  got_res.granted_address, got_res.status));
        end else begin
          want_res = awaited_grants.pop_front();
          if (got_res.granted_address !== want_res.granted_address) begin
            flag_mismatch($sformatf("granted_address got %h want %h",
                                    got_res.granted_address, want_res.granted_address));
          end
          if (got_res.status !== want_res.status) begin
            flag_mismatch($sformatf("status got %0d want %0d",
                                    got_res.status, want_res.status));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_data.func == FUNC_ALLOC) begin
          place_region(in_data.request_size, new_res);
        end else begin
          release_region(in_data.free_address, new_res);
        end
        awaited_grants.push_back(new_res);
      end
      pending <= awaited_grants.size();
    end
  end

endmodule

/* test/tb_first_fit_region_allocator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_region_allocator_core
// Stimulus and verdict for the first-fit region allocator core.
// ----------------------------------------------------------------------------
// A directed opening walks empty-table frees, zero-size and oversize requests,
// frees of the window bounds and a fill up to a full table. Eight random
// phases follow, each with its own window (empty, full address space, windows
// that cross the top of the address space, shifted windows over old regions)
// and one of four mixes of sender gaps and receiver stalls. Frees mostly target
// addresses that the core granted earlier. The checker beside the core does
// all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_first_fit_region_allocator_core;
  import ffra_pkg::*;

  localparam int MAX_REGIONS  = 16;
  localparam int PHASES       = 8;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int POOL_DEPTH   = 64;
  localparam int SETTLE       = 40;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int          fail_count;
  int          pending;
  int          idle_pct;
  int          stall_pct;
  int          alloc_pct;
  int          cycle_count;
  logic [31:0] win_base;
  logic [31:0] win_size;
  logic [31:0] granted_pool [$];

  first_fit_region_allocator_core #(
    .MAX_REGIONS(MAX_REGIONS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  first_fit_region_allocator_checker #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Harvest granted addresses as free targets
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall && out_data.status == STATUS_DONE &&
        granted_pool.size() < POOL_DEPTH) begin
      granted_pool.push_back(out_data.granted_address);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Hold valid until the core takes the write; the caller lowers it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_window(input logic [31:0] base, input logic [31:0] size);
    write_reg(CFG_REGION_BASE, base);
    write_reg(CFG_REGION_SIZE, size);
    cfg_valid <= 1'b0;
    win_base = base;
    win_size = size;
  endtask

  task automatic send(input in_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_op(input logic func, input logic [31:0] size, input logic [31:0] addr);
    in_t item;
    item.func         = func;
    item.request_size = size;
    item.free_address = addr;
    send(item);
  endtask

  // Stop sending until every outstanding grant has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 11) return $urandom;
    if (r < 14) return 32'hFFFF_FFFF;
    if (r < 19) return win_size;
    if (r < 22) return win_size + 32'd1;
    return $urandom_range((win_size >> 3) + 1, 1);
  endfunction

  function automatic logic [31:0] pick_free();
    int r;
    int idx;
    r = $urandom_range(99);
    if (r < 75 && granted_pool.size() > 0) begin
      idx = $urandom_range(granted_pool.size() - 1);
      pick_free = granted_pool[idx];
      granted_pool.delete(idx);
    end else if (r < 82) begin
      pick_free = win_base;
    end else if (r < 88) begin
      pick_free = win_base + win_size;
    end else begin
      pick_free = $urandom;
    end
  endfunction

  task automatic send_random();
    in_t item;
    item.request_size = $urandom;
    item.free_address = $urandom;
    if ($urandom_range(99) < alloc_pct) begin
      item.func         = FUNC_ALLOC;
      item.request_size = pick_size();
    end else begin
      item.func         = FUNC_FREE;
      item.free_address = pick_free();
    end
    send(item);
  endtask

  initial begin
    int p;
    int n;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_pct  = 0;
    stall_pct = 0;
    alloc_pct = 60;
    win_base  = '0;
    win_size  = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    set_window(32'h0000_1000, 32'h0000_1000);
    send_op(FUNC_FREE, $urandom, win_base);               // empty table
    send_op(FUNC_ALLOC, 32'd0, $urandom);                 // zero size at window start
    send_op(FUNC_ALLOC, 32'h100, $urandom);
    send_op(FUNC_ALLOC, 32'hFFFF_FFFF, $urandom);         // never fits
    send_op(FUNC_ALLOC, win_size, $urandom);              // no gap left that large
    send_op(FUNC_FREE, $urandom, win_base + win_size);    // window end is no entry
    send_op(FUNC_FREE, $urandom, win_base);               // first match: zero-size one
    send_op(FUNC_FREE, $urandom, win_base);
    for (n = 0; n < MAX_REGIONS; n++) begin
      send_op(FUNC_ALLOC, 32'h40, $urandom);
    end
    send_op(FUNC_ALLOC, 32'd0, $urandom);                 // table full

    for (p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: set_window(32'h0000_1000, 32'h0000_1000);
        1: set_window(32'h0000_0000, 32'hFFFF_FFFF);
        2: set_window(32'hFFFF_F000, 32'h0000_2000);
        3: begin
          write_reg(CFG_UNUSED_LO, $urandom);
          write_reg(CFG_UNUSED_HI, $urandom);
          set_window(32'h8000_0000, 32'h0000_0000);
        end
        4: set_window(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        5: set_window(32'h0000_1800, 32'h0000_0800);
        6: set_window(32'h0000_0000, 32'h0000_0000);
        default: set_window($urandom, $urandom_range(4096, 16));
      endcase
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        // swing the mix so the table both fills up and empties
        if (n % 40 == 0) alloc_pct = $urandom_range(85, 30);
        send_random();
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
